FILE: rtl/eflha_pkg.sv
// Shared constants, codes and payload types of the free-list heap allocator.
package eflha_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 4096;  // default heap storage in bytes
  localparam int unsigned HEAP_RESET     = 4096;  // heap_bytes after reset, before clamping
  localparam int unsigned ALIGN_BYTES    = 8;
  localparam int unsigned MAX_REQUEST    = 4096;
  localparam int unsigned WORD_BYTES     = 8;     // heap bytes per stored word
  localparam int unsigned MIN_PAYLOAD    = 16;
  localparam int unsigned SPLIT_UNITS    = 3;

  localparam int unsigned OFF_W  = 17;  // byte offsets and offset sums
  localparam int unsigned DATA_W = 16;  // stored word
  localparam int unsigned REQ_W  = 17;  // saturated rounded request
  localparam int unsigned CFG_W  = 13;

  localparam logic [DATA_W-1:0] USED_MASK = 16'h0007;
  localparam logic [DATA_W-1:0] SIZE_MASK = 16'hFFF8;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] size;
    logic        has_address;
    logic [11:0] address;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] result_address;
    logic [11:0] copy_bytes;
  } rsp_t;

endpackage

FILE: rtl/eflha_ram.sv
// Generic single-clock RAM, one write and one registered read port.
module eflha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/explicit_free_list_heap_allocator_core.sv
// Explicit free-list heap allocator: request sequencer over one heap word RAM.
// Sequencing: one request at a time; a heap read returns its word from the registered RAM read port.
//   Allocate walks the free-list entries; free and resize first walk the block headers by address,
//   then release, merge or split, and a moving resize also allocates a new block.
// The next request is taken once the result sits in the output register.
// Reset: the init states S_INIT0, S_INIT1, S_INIT2 write the single free block header and its links;
//   a heap_bytes write of at least MinHeap re-runs the same init states.
module explicit_free_list_heap_allocator_core #(
  parameter int unsigned HEAP_BYTES = eflha_pkg::HEAP_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  eflha_pkg::req_t                 in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output eflha_pkg::rsp_t                 out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [eflha_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned OW    = eflha_pkg::OFF_W;
  localparam int unsigned DW    = eflha_pkg::DATA_W;
  localparam int unsigned RW    = eflha_pkg::REQ_W;
  localparam int unsigned Words = HEAP_BYTES / eflha_pkg::WORD_BYTES;
  localparam int unsigned AW    = $clog2(Words);
  localparam int unsigned IW    = OW - 3;

  localparam logic [OW-1:0] Align    = OW'(eflha_pkg::ALIGN_BYTES);
  localparam logic [OW-1:0] PrevOff  = OW'(eflha_pkg::ALIGN_BYTES);
  localparam logic [OW-1:0] NextOff  = OW'(eflha_pkg::ALIGN_BYTES + 8);
  localparam logic [OW-1:0] HeapMax  = OW'(HEAP_BYTES);
  localparam logic [OW-1:0] MinHeap  = OW'(eflha_pkg::SPLIT_UNITS * eflha_pkg::ALIGN_BYTES);
  localparam logic [RW:0]   SplitAdd = (RW+1)'(eflha_pkg::SPLIT_UNITS * eflha_pkg::ALIGN_BYTES);
  localparam logic [RW-1:0] MaxReq   = RW'(eflha_pkg::MAX_REQUEST);
  localparam logic [IW-1:0] WordsL   = IW'(Words);
  localparam int unsigned   HbRst0   = (eflha_pkg::HEAP_RESET > HEAP_BYTES) ?
                                       HEAP_BYTES : eflha_pkg::HEAP_RESET;
  localparam logic [OW-1:0] HbReset  = OW'(HbRst0 - (HbRst0 % eflha_pkg::ALIGN_BYTES));

  // one-hot sequencer; subroutines (list push/remove, absorb, split, alloc, release)
  // return through per-routine return-state registers
  typedef enum logic [40:0] {
    S_INIT0 = 41'd1 << 0,  S_INIT1 = 41'd1 << 1,  S_INIT2 = 41'd1 << 2,
    S_IDLE  = 41'd1 << 3,  S_DISP  = 41'd1 << 4,  S_TA    = 41'd1 << 5,
    S_FU0   = 41'd1 << 6,  S_FU1   = 41'd1 << 7,  S_RZ0   = 41'd1 << 8,
    S_RZ1   = 41'd1 << 9,  S_RZ2   = 41'd1 << 10, S_RZ3   = 41'd1 << 11,
    S_RZ4   = 41'd1 << 12, S_RZOK  = 41'd1 << 13, S_RZ5   = 41'd1 << 14,
    S_RZ6   = 41'd1 << 15, S_AL0   = 41'd1 << 16, S_AL1   = 41'd1 << 17,
    S_AL2   = 41'd1 << 18, S_AL3   = 41'd1 << 19, S_AL4   = 41'd1 << 20,
    S_RL0   = 41'd1 << 21, S_RL1   = 41'd1 << 22, S_RL2   = 41'd1 << 23,
    S_SP0   = 41'd1 << 24, S_SP1   = 41'd1 << 25, S_SP2   = 41'd1 << 26,
    S_SP3   = 41'd1 << 27, S_SP4   = 41'd1 << 28, S_AB0   = 41'd1 << 29,
    S_AB1   = 41'd1 << 30, S_AB2   = 41'd1 << 31, S_AB3   = 41'd1 << 32,
    S_RM0   = 41'd1 << 33, S_RM1   = 41'd1 << 34, S_RM2   = 41'd1 << 35,
    S_RM3   = 41'd1 << 36, S_PU0   = 41'd1 << 37, S_PU1   = 41'd1 << 38,
    S_PU2   = 41'd1 << 39, S_OUT   = 41'd1 << 40
  } state_e;

  function automatic logic [OW-1:0] blk_sz(input logic [DW-1:0] w);
    blk_sz = OW'(w & eflha_pkg::SIZE_MASK);
  endfunction

  function automatic logic is_free(input logic [DW-1:0] w);
    is_free = (w & eflha_pkg::USED_MASK) == '0;
  endfunction

  // control state
  state_e          state_q, state_d;
  state_e          rm_ret_q, rm_ret_d, pu_ret_q, pu_ret_d, ab_ret_q, ab_ret_d;
  state_e          sp_ret_q, sp_ret_d, al_ret_q, al_ret_d, rl_ret_q, rl_ret_d;
  logic [OW-1:0]   hb_q, hb_d;
  logic [DW-1:0]   head_q, head_d;
  logic            out_valid_q, out_valid_d;
  logic            rd_ok_q, rd_ok_d;

  // request and working registers
  logic [1:0]      op_q, op_d;
  logic [RW-1:0]   req_q, req_d;
  logic            zero_q, zero_d, has_q, has_d;
  logic [11:0]     addr_q, addr_d;
  logic [OW-1:0]   b_q, b_d;
  logic [DW-1:0]   hdr_q, hdr_d, old_q, old_d;
  logic [DW-1:0]   al_cur_q, al_cur_d, al_hdr_q, al_hdr_d;
  logic [OW-1:0]   al_b_q, al_b_d;
  logic            al_ok_q, al_ok_d;
  logic [OW-1:0]   rl_b_q, rl_b_d, sp_b_q, sp_b_d, ab_b_q, ab_b_d, ab_nb_q, ab_nb_d;
  logic [DW-1:0]   sp_hdr_q, sp_hdr_d, ab_hdr_q, ab_hdr_d, ab_nbh_q, ab_nbh_d;
  logic [OW-1:0]   rm_b_q, rm_b_d, pu_b_q, pu_b_d;
  logic [DW-1:0]   rm_p_q, rm_p_d;
  logic [DW-1:0]   rm_n_q, rm_n_d;
  logic            res_ok_q, res_ok_d;
  logic [11:0]     res_addr_q, res_addr_d, res_copy_q, res_copy_d;
  eflha_pkg::rsp_t out_data_q, out_data_d;

  // heap memory access
  logic            rd_en, wr_en;
  logic [OW-1:0]   rd_off, wr_off;
  logic [DW-1:0]   wr_val;
  logic [IW-1:0]   rd_idx, wr_idx;
  logic            ram_re, ram_we;
  logic [DW-1:0]   ram_rdata, rdat;

  // helpers
  logic [OW-1:0]   cfg_v, t_off, sp_nb, rz_nb, al_pv, rz_pv;
  logic [32:0]     round_s;
  logic [RW:0]     req_plus;

  assign rd_idx = rd_off[OW-1:3];
  assign wr_idx = wr_off[OW-1:3];
  assign ram_re = rd_en && (rd_idx < WordsL);
  assign ram_we = wr_en && (wr_idx < WordsL);
  assign rd_ok_d = ram_re;
  // reads beyond the stored words return zero
  assign rdat = rd_ok_q ? ram_rdata : '0;

  eflha_ram #(
    .WIDTH (DW),
    .DEPTH (Words)
  ) u_heap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx[AW-1:0]),
    .wdata_i (wr_val),
    .re_i    (ram_re),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    // heap_bytes write: clamp, align down
    cfg_v = (OW'(cfg_data_i) > HeapMax) ? HeapMax : OW'(cfg_data_i);
    cfg_v = cfg_v & ~(Align - OW'(1));
    // round the request up to alignment, minimum payload, saturate above REQ_W bits
    round_s = {1'b0, in_data_i.size} + 33'(eflha_pkg::ALIGN_BYTES - 1);
    round_s = round_s & ~33'(eflha_pkg::ALIGN_BYTES - 1);
    if (round_s < 33'(eflha_pkg::MIN_PAYLOAD)) begin
      round_s = 33'(eflha_pkg::MIN_PAYLOAD);
    end
    req_plus = {1'b0, req_q} + SplitAdd;
    t_off    = OW'(addr_q) - Align;
    sp_nb    = sp_b_q + Align + OW'(req_q);
    rz_nb    = b_q + Align + OW'(req_q);
    al_pv    = blk_sz(al_hdr_q);
    rz_pv    = blk_sz(hdr_q);
  end

  always_comb begin
    state_d     = state_q;
    rm_ret_d    = rm_ret_q;
    pu_ret_d    = pu_ret_q;
    ab_ret_d    = ab_ret_q;
    sp_ret_d    = sp_ret_q;
    al_ret_d    = al_ret_q;
    rl_ret_d    = rl_ret_q;
    hb_d        = hb_q;
    head_d      = head_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    op_d        = op_q;
    req_d       = req_q;
    zero_d      = zero_q;
    has_d       = has_q;
    addr_d      = addr_q;
    b_d         = b_q;
    hdr_d       = hdr_q;
    old_d       = old_q;
    al_cur_d    = al_cur_q;
    al_hdr_d    = al_hdr_q;
    al_b_d      = al_b_q;
    al_ok_d     = al_ok_q;
    rl_b_d      = rl_b_q;
    sp_b_d      = sp_b_q;
    sp_hdr_d    = sp_hdr_q;
    ab_b_d      = ab_b_q;
    ab_nb_d     = ab_nb_q;
    ab_hdr_d    = ab_hdr_q;
    ab_nbh_d    = ab_nbh_q;
    rm_b_d      = rm_b_q;
    rm_p_d      = rm_p_q;
    rm_n_d      = rm_n_q;
    pu_b_d      = pu_b_q;
    res_ok_d    = res_ok_q;
    res_addr_d  = res_addr_q;
    res_copy_d  = res_copy_q;
    rd_en       = 1'b0;
    rd_off      = '0;
    wr_en       = 1'b0;
    wr_off      = '0;
    wr_val      = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // heap init: one free block, empty links, head names it
      S_INIT0: begin
        wr_en   = 1'b1;
        wr_off  = '0;
        wr_val  = DW'(hb_q - Align);
        state_d = S_INIT1;
      end
      S_INIT1: begin
        wr_en   = 1'b1;
        wr_off  = PrevOff;
        state_d = S_INIT2;
      end
      S_INIT2: begin
        wr_en   = 1'b1;
        wr_off  = NextOff;
        head_d  = DW'(1);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          // short heap values are dropped
          if (cfg_v >= MinHeap) begin
            hb_d    = cfg_v;
            state_d = S_INIT0;
          end
        end else if (in_valid_i) begin
          op_d       = in_data_i.operation;
          req_d      = (|round_s[32:RW]) ? '1 : round_s[RW-1:0];
          zero_d     = (in_data_i.size == '0);
          has_d      = in_data_i.has_address;
          addr_d     = in_data_i.address;
          res_ok_d   = 1'b0;
          res_addr_d = '0;
          res_copy_d = '0;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        b_d = '0;
        if (op_q == eflha_pkg::OP_ALLOC || (op_q == eflha_pkg::OP_RESIZE && !has_q)) begin
          al_cur_d = head_q;
          al_ok_d  = 1'b0;
          al_ret_d = S_TA;
          state_d  = S_AL0;
        end else if ((op_q == eflha_pkg::OP_FREE || op_q == eflha_pkg::OP_RESIZE) &&
                     has_q && OW'(addr_q) >= Align) begin
          state_d = S_FU0;
        end else begin
          state_d = S_OUT;
        end
      end
      S_TA: begin
        res_ok_d   = al_ok_q;
        res_addr_d = al_ok_q ? al_b_q[11:0] + 12'(eflha_pkg::ALIGN_BYTES) : '0;
        state_d    = S_OUT;
      end
      // address check: walk headers from the heap start
      S_FU0: begin
        if (b_q >= hb_q || b_q > t_off) begin
          state_d = S_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_off  = b_q;
          state_d = S_FU1;
        end
      end
      S_FU1: begin
        if (b_q == t_off) begin
          hdr_d = rdat;
          old_d = rdat & eflha_pkg::SIZE_MASK;
          if (is_free(rdat)) begin
            state_d = S_OUT;
          end else if (op_q == eflha_pkg::OP_FREE || zero_q) begin
            rl_b_d   = b_q;
            rl_ret_d = S_OUT;
            state_d  = S_RL0;
          end else begin
            state_d = S_RZ0;
          end
        end else begin
          b_d     = b_q + Align + blk_sz(rdat);
          state_d = S_FU0;
        end
      end
      // resize: merge free right neighbors until the request fits, else allocate a new block and release
      S_RZ0: begin
        rd_en   = 1'b1;
        rd_off  = b_q;
        state_d = S_RZ1;
      end
      S_RZ1: begin
        hdr_d = rdat;
        if (blk_sz(rdat) >= OW'(req_q) && req_q[RW-1:OW-1] == '0) begin
          state_d = S_RZ3;
        end else if (b_q + Align + blk_sz(rdat) >= hb_q) begin
          state_d = S_RZ3;
        end else begin
          rd_en   = 1'b1;
          rd_off  = b_q + Align + blk_sz(rdat);
          state_d = S_RZ2;
        end
      end
      S_RZ2: begin
        if (!is_free(rdat)) begin
          state_d = S_RZ3;
        end else begin
          ab_b_d   = b_q;
          ab_ret_d = S_RZ0;
          state_d  = S_AB0;
        end
      end
      S_RZ3: begin
        if ((RW+1)'(rz_pv) >= (RW+1)'(req_q)) begin
          if (b_q + Align + rz_pv == hb_q && req_plus < (RW+1)'(rz_pv)) begin
            // last block: cut the tail off as a new free block
            wr_en   = 1'b1;
            wr_off  = rz_nb;
            wr_val  = DW'(rz_pv - OW'(req_q) - Align);
            state_d = S_RZ4;
          end else if (b_q + Align + rz_pv != hb_q && (RW+1)'(old_q) >= req_plus) begin
            sp_b_d   = b_q;
            sp_ret_d = S_RZOK;
            state_d  = S_SP0;
          end else begin
            state_d = S_RZOK;
          end
        end else begin
          al_cur_d = head_q;
          al_ok_d  = 1'b0;
          al_ret_d = S_RZ5;
          state_d  = S_AL0;
        end
      end
      S_RZ4: begin
        wr_en    = 1'b1;
        wr_off   = b_q;
        wr_val   = DW'(req_q) + DW'(1);
        pu_b_d   = rz_nb;
        pu_ret_d = S_RZOK;
        state_d  = S_PU0;
      end
      S_RZOK: begin
        res_ok_d   = 1'b1;
        res_addr_d = addr_q;
        state_d    = S_OUT;
      end
      S_RZ5: begin
        if (al_ok_q) begin
          rl_b_d   = b_q;
          rl_ret_d = S_RZ6;
          state_d  = S_RL0;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RZ6: begin
        res_ok_d   = 1'b1;
        res_addr_d = al_b_q[11:0] + 12'(eflha_pkg::ALIGN_BYTES);
        res_copy_d = old_q[11:0];
        state_d    = S_OUT;
      end
      // allocate: first fit along the free list
      S_AL0: begin
        if (req_q > MaxReq || !al_cur_q[0]) begin
          state_d = al_ret_q;
        end else begin
          al_b_d  = OW'(al_cur_q & eflha_pkg::SIZE_MASK);
          rd_en   = 1'b1;
          rd_off  = OW'(al_cur_q & eflha_pkg::SIZE_MASK);
          state_d = S_AL1;
        end
      end
      S_AL1: begin
        if (is_free(rdat) && OW'(blk_sz(rdat)) >= OW'(req_q)) begin
          al_hdr_d = rdat;
          state_d  = S_AL2;
        end else begin
          rd_en   = 1'b1;
          rd_off  = al_b_q + NextOff;
          state_d = S_AL4;
        end
      end
      S_AL4: begin
        al_cur_d = rdat;
        state_d  = S_AL0;
      end
      S_AL2: begin
        if (al_b_q + Align + al_pv == hb_q && (RW+1)'(al_pv) >= req_plus) begin
          sp_b_d   = al_b_q;
          sp_ret_d = S_AL3;
          state_d  = S_SP0;
        end else begin
          wr_en    = 1'b1;
          wr_off   = al_b_q;
          wr_val   = al_hdr_q + DW'(1);
          rm_b_d   = al_b_q;
          rm_ret_d = S_AL3;
          state_d  = S_RM0;
        end
      end
      S_AL3: begin
        al_ok_d = 1'b1;
        state_d = al_ret_q;
      end
      // release: clear used bit, push, merge right
      S_RL0: begin
        rd_en   = 1'b1;
        rd_off  = rl_b_q;
        state_d = S_RL1;
      end
      S_RL1: begin
        wr_en    = 1'b1;
        wr_off   = rl_b_q;
        wr_val   = rdat & eflha_pkg::SIZE_MASK;
        pu_b_d   = rl_b_q;
        pu_ret_d = S_RL2;
        state_d  = S_PU0;
      end
      S_RL2: begin
        ab_b_d   = rl_b_q;
        ab_ret_d = rl_ret_q;
        state_d  = S_AB0;
      end
      // split at req bytes, tail becomes a free block
      S_SP0: begin
        rd_en   = 1'b1;
        rd_off  = sp_b_q;
        state_d = S_SP1;
      end
      S_SP1: begin
        sp_hdr_d = rdat;
        wr_en    = 1'b1;
        wr_off   = sp_b_q;
        wr_val   = DW'(req_q) + DW'(1);
        state_d  = S_SP2;
      end
      S_SP2: begin
        wr_en  = 1'b1;
        wr_off = sp_nb;
        wr_val = DW'(blk_sz(sp_hdr_q) - OW'(req_q) - Align);
        if (is_free(sp_hdr_q)) begin
          rm_b_d   = sp_b_q;
          rm_ret_d = S_SP3;
          state_d  = S_RM0;
        end else begin
          state_d = S_SP3;
        end
      end
      S_SP3: begin
        pu_b_d   = sp_nb;
        pu_ret_d = S_SP4;
        state_d  = S_PU0;
      end
      S_SP4: begin
        ab_b_d   = sp_nb;
        ab_ret_d = sp_ret_q;
        state_d  = S_AB0;
      end
      // absorb a free right neighbor
      S_AB0: begin
        rd_en   = 1'b1;
        rd_off  = ab_b_q;
        state_d = S_AB1;
      end
      S_AB1: begin
        ab_hdr_d = rdat;
        ab_nb_d  = ab_b_q + Align + blk_sz(rdat);
        if (ab_b_q + Align + blk_sz(rdat) >= hb_q) begin
          state_d = ab_ret_q;
        end else begin
          rd_en   = 1'b1;
          rd_off  = ab_b_q + Align + blk_sz(rdat);
          state_d = S_AB2;
        end
      end
      S_AB2: begin
        ab_nbh_d = rdat;
        if (!is_free(rdat)) begin
          state_d = ab_ret_q;
        end else begin
          rm_b_d   = ab_nb_q;
          rm_ret_d = S_AB3;
          state_d  = S_RM0;
        end
      end
      S_AB3: begin
        wr_en   = 1'b1;
        wr_off  = ab_b_q;
        wr_val  = ab_hdr_q + (ab_nbh_q & eflha_pkg::SIZE_MASK) + DW'(eflha_pkg::ALIGN_BYTES);
        state_d = ab_ret_q;
      end
      // unlink from the free list
      S_RM0: begin
        rd_en   = 1'b1;
        rd_off  = rm_b_q + PrevOff;
        state_d = S_RM1;
      end
      S_RM1: begin
        rm_p_d  = rdat;
        rd_en   = 1'b1;
        rd_off  = rm_b_q + NextOff;
        state_d = S_RM2;
      end
      S_RM2: begin
        rm_n_d = rdat;
        if (rdat[0]) begin
          wr_en  = 1'b1;
          wr_off = OW'(rdat & eflha_pkg::SIZE_MASK) + PrevOff;
          wr_val = rm_p_q[0] ? rm_p_q : '0;
        end
        if (!rm_p_q[0]) begin
          head_d  = rdat;
          state_d = rm_ret_q;
        end else begin
          state_d = S_RM3;
        end
      end
      S_RM3: begin
        wr_en   = 1'b1;
        wr_off  = OW'(rm_p_q & eflha_pkg::SIZE_MASK) + NextOff;
        wr_val  = rm_n_q;
        state_d = rm_ret_q;
      end
      // push at the list head
      S_PU0: begin
        if (head_q[0]) begin
          wr_en  = 1'b1;
          wr_off = OW'(head_q & eflha_pkg::SIZE_MASK) + PrevOff;
          wr_val = DW'(pu_b_q) | DW'(1);
        end
        state_d = S_PU1;
      end
      S_PU1: begin
        wr_en   = 1'b1;
        wr_off  = pu_b_q + NextOff;
        wr_val  = head_q;
        state_d = S_PU2;
      end
      S_PU2: begin
        wr_en   = 1'b1;
        wr_off  = pu_b_q + PrevOff;
        head_d  = DW'(pu_b_q) | DW'(1);
        state_d = pu_ret_q;
      end
      // result word waits for a free output register
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_data_d.ok              = res_ok_q;
          out_data_d.result_address  = res_ok_q ? res_addr_q : '0;
          out_data_d.copy_bytes      = res_ok_q ? res_copy_q : '0;
          state_d                    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT0;
      rm_ret_q    <= S_IDLE;
      pu_ret_q    <= S_IDLE;
      ab_ret_q    <= S_IDLE;
      sp_ret_q    <= S_IDLE;
      al_ret_q    <= S_IDLE;
      rl_ret_q    <= S_IDLE;
      hb_q        <= HbReset;
      head_q      <= DW'(1);
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      rm_ret_q    <= rm_ret_d;
      pu_ret_q    <= pu_ret_d;
      ab_ret_q    <= ab_ret_d;
      sp_ret_q    <= sp_ret_d;
      al_ret_q    <= al_ret_d;
      rl_ret_q    <= rl_ret_d;
      hb_q        <= hb_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      rd_ok_q     <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    op_q       <= op_d;
    req_q      <= req_d;
    zero_q     <= zero_d;
    has_q      <= has_d;
    addr_q     <= addr_d;
    b_q        <= b_d;
    hdr_q      <= hdr_d;
    old_q      <= old_d;
    al_cur_q   <= al_cur_d;
    al_hdr_q   <= al_hdr_d;
    al_b_q     <= al_b_d;
    al_ok_q    <= al_ok_d;
    rl_b_q     <= rl_b_d;
    sp_b_q     <= sp_b_d;
    sp_hdr_q   <= sp_hdr_d;
    ab_b_q     <= ab_b_d;
    ab_nb_q    <= ab_nb_d;
    ab_hdr_q   <= ab_hdr_d;
    ab_nbh_q   <= ab_nbh_d;
    rm_b_q     <= rm_b_d;
    rm_p_q     <= rm_p_d;
    rm_n_q     <= rm_n_d;
    pu_b_q     <= pu_b_d;
    res_ok_q   <= res_ok_d;
    res_addr_q <= res_addr_d;
    res_copy_q <= res_copy_d;
  end

`ifndef ASSERT_OFF
  // a taken request always starts the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // no read and write of one word in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (wr_idx != rd_idx))
    else $error("heap word read and written in one cycle");

  // free-list head points inside the heap when idle
  a_head_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && head_q[0]) |-> (OW'(head_q & eflha_pkg::SIZE_MASK) < hb_q))
    else $error("free-list head outside heap");

  // a heap_bytes write either re-inits or is dropped
  a_cfg_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (state_q == S_INIT0 || state_q == S_IDLE))
    else $error("heap_bytes write not followed by init");
`endif

endmodule
